### hdl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/pgps_pkg.sv
// shared types and constants of the panorama grid position sequencer
// used by the pgps modules other than pgps_div; no dependencies
package pgps_pkg;

  localparam int IW         = 18;
  localparam int CFG_IW     = 2;
  localparam int CFG_DW     = 17;
  localparam int DW         = 26;
  localparam int STEP_W     = 17;
  localparam int MOVE_W     = 24;
  localparam int CNT_OUT_W  = 10;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 88;

  localparam int Q          = 256;
  localparam int PCT        = 100;
  localparam int FULL_DEG   = 360;
  localparam int HALF_DEG   = 180;
  localparam int HALF_TURN  = HALF_DEG * Q;
  localparam int FULL_TURN  = FULL_DEG * Q;
  localparam int TRIM_DIV   = Q * PCT;

  // floor(y / 100) as (y * TRIM_RECIP) >> TRIM_SHIFT, exact for y up to 36100
  localparam int TRIM_RECIP = 5243;
  localparam int TRIM_SHIFT = 19;

  localparam int OVERLAP_DEF  = 20;
  localparam int MAX_GRID_DEF = 512;

  localparam logic [CFG_IW-1:0] CFG_PANO_W = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PANO_H = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_LENS_W = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_LENS_H = 2'd3;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_NEXT     = 3'd1,
    MODE_PREV     = 3'd2,
    MODE_GOTO_RC  = 3'd3,
    MODE_GOTO_IDX = 3'd4,
    MODE_END      = 3'd5,
    MODE_HOME     = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    DS_CNT,
    DS_STEP,
    DS_CUR,
    DS_TGT
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_AXIS,
    ST_TRIM,
    ST_CNT_GO,
    ST_CNT_DIV,
    ST_STEP_GO,
    ST_STEP_DIV,
    ST_AXIS_END,
    ST_CUR_DIV,
    ST_TGT_GO,
    ST_TGT_DIV,
    ST_MUL,
    ST_APPLY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     axis;
    logic     div_go;
    div_sel_t div_sel;
    logic     trim_go;
    logic     take_tdeg;
    logic     full_tdeg;
    logic     take_cnt;
    logic     take_step;
    logic     big_fit;
    logic     start_clr;
    logic     take_cur;
    logic     take_tgt;
    logic     tgt_in;
    logic     tgt_zero;
    logic     mul;
    logic     apply;
    logic     home;
    logic     reject;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  div_done;
    logic  div_busy;
    logic  lens_big;
    logic  full_circle;
    logic  cur_zero;
    logic  out_free;
  } stat_t;

endpackage

### hdl/pgps_div.sv
// restoring divider, one quotient bit per cycle
// no package dependencies
module pgps_div #(
  parameter int W = 26
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem,
  output logic         busy,
  output logic         done
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_q;
  logic [W-1:0]     quo_q;
  logic [W-1:0]     dvs_q;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       trial;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= '0;
      quo_q <= dividend;
      dvs_q <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
      end else begin
        rem_q <= {rem_q[W-2:0], quo_q[W-1]};
      end
      quo_q <= {quo_q[W-2:0], ~trial[W]};
    end
  end

  assign quo = quo_q;
  assign rem = rem_q;

endmodule

### hdl/pgps_datapath.sv
// datapath: configuration, grid state, offsets, divider operands and result register
// depends on pgps_pkg and pgps_div
module pgps_datapath #(
  parameter int OVERLAP_PERCENT = pgps_pkg::OVERLAP_DEF,
  parameter int MAX_GRID        = pgps_pkg::MAX_GRID_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pgps_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [pgps_pkg::CFG_DW-1:0]        cfg_data,
  input  logic [pgps_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [pgps_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  pgps_pkg::cmd_t                     cmd,
  output pgps_pkg::stat_t                    stat
);

  localparam int IW = pgps_pkg::IW;
  localparam int DW = pgps_pkg::DW;
  localparam int SW = pgps_pkg::STEP_W;
  localparam int MW = pgps_pkg::MOVE_W;
  localparam int CW = $clog2(MAX_GRID + 1);
  localparam int PW = CW + 1 + SW + 1;
  localparam int HW = (PW > MW) ? PW : MW;
  localparam int XW = (2 * CW + 1 > IW) ? 2 * CW + 1 : IW;
  localparam logic signed [HW-1:0] HALF_S = HW'(pgps_pkg::HALF_TURN);
  localparam logic signed [HW-1:0] FULL_S = HW'(pgps_pkg::FULL_TURN);

  // configuration
  logic [8:0]  pano_w;
  logic [7:0]  pano_h;
  logic [16:0] lens_w;
  logic [15:0] lens_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      pano_w <= 9'd360;
      pano_h <= 8'd180;
      lens_w <= 17'd16384;
      lens_h <= 16'd10240;
    end else if (cfg_we) begin
      case (cfg_index)
        pgps_pkg::CFG_PANO_W: begin
          if (cfg_data[8:0] != 9'd0 && cfg_data[8:0] <= 9'd360) pano_w <= cfg_data[8:0];
        end
        pgps_pkg::CFG_PANO_H: begin
          if (cfg_data[7:0] != 8'd0 && cfg_data[7:0] <= 8'd180) pano_h <= cfg_data[7:0];
        end
        pgps_pkg::CFG_LENS_W: begin
          if (cfg_data != 17'd0) lens_w <= cfg_data;
        end
        pgps_pkg::CFG_LENS_H: begin
          if (cfg_data[15:0] != 16'd0) lens_h <= cfg_data[15:0];
        end
        default: ;
      endcase
    end
  end

  // latched command
  pgps_pkg::mode_t mode_q;
  logic [8:0]      trow_q;
  logic [8:0]      tcol_q;
  logic [IW-1:0]   tidx_q;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_q <= pgps_pkg::mode_t'(s_tdata[2:0]);
      trow_q <= s_tdata[11:3];
      tcol_q <= s_tdata[20:12];
      tidx_q <= s_tdata[38:21];
    end
  end

  // grid state
  logic [IW-1:0]        cur_index;
  logic [CW-1:0]        col_count, row_count;
  logic [SW-1:0]        col_step, row_step;
  logic [MW-1:0]        pan_off, tilt_off;
  logic [8:0]           tdeg_q;
  logic [15:0]          trim_q;
  logic [CW-1:0]        n_q;
  logic [IW-1:0]        cr_q, tr_q, tc_q;
  logic [CW-1:0]        cc_q;
  logic signed [PW-1:0] hp_q, vp_q;
  logic [IW-1:0]        idx_q;
  logic                 in_rng_q;
  logic                 res_ok;
  logic [MW-1:0]        res_pan, res_tilt;

  // axis selection
  logic [8:0]  tot_deg;
  logic [16:0] lens;
  assign tot_deg = cmd.axis ? {1'b0, pano_h} : pano_w;
  assign lens    = cmd.axis ? {1'b0, lens_h} : lens_w;

  // trimmed angle: ceil of x / 25600, as a shift by 8 then a reciprocal multiply for / 100
  logic [DW-1:0] trim_x;
  logic [31:0]   trim_prod;
  assign trim_x = DW'(tot_deg) * DW'(pgps_pkg::TRIM_DIV) - DW'(lens) * DW'(OVERLAP_PERCENT)
                  + DW'(pgps_pkg::TRIM_DIV - 1);
  assign trim_prod = 32'(trim_q) * 32'(pgps_pkg::TRIM_RECIP);

  // divider operands
  logic [DW-1:0] span, dvs_d, dvd, dvs, quo, rem;
  logic          div_busy, div_done;

  assign span  = DW'({tdeg_q, 8'b0});
  assign dvs_d = DW'(lens) * DW'(pgps_pkg::PCT - OVERLAP_PERCENT);

  always_comb begin
    dvd = '0;
    dvs = DW'(1);
    case (cmd.div_sel)
      pgps_pkg::DS_CNT: begin
        dvd = span * DW'(pgps_pkg::PCT) + dvs_d - DW'(1);
        dvs = dvs_d;
      end
      pgps_pkg::DS_STEP: begin
        dvd = span + DW'(n_q >> 1);
        dvs = DW'(n_q);
      end
      pgps_pkg::DS_CUR: begin
        dvd = DW'(cur_index);
        dvs = DW'(col_count);
      end
      pgps_pkg::DS_TGT: begin
        case (mode_q)
          pgps_pkg::MODE_NEXT: dvd = DW'(cur_index) + DW'(1);
          pgps_pkg::MODE_PREV: dvd = DW'(cur_index) - DW'(1);
          default:             dvd = DW'(tidx_q);
        endcase
        dvs = DW'(col_count);
      end
      default: ;
    endcase
  end

  pgps_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .quo      (quo),
    .rem      (rem),
    .busy     (div_busy),
    .done     (div_done)
  );

  logic [CW-1:0] n_clamp;
  assign n_clamp = (quo > DW'(MAX_GRID)) ? CW'(MAX_GRID) : CW'(quo);

  // move arithmetic
  logic signed [CW:0]   dc, dr;
  logic signed [PW-1:0] hp_d, vp_d;
  logic [XW-1:0]        idx_calc;
  logic                 in_rng;
  logic signed [HW-1:0] hx, h, v;

  assign dc = signed'({1'b0, tc_q[CW-1:0]}) - signed'({1'b0, cc_q});
  assign dr = signed'({1'b0, cr_q[CW-1:0]}) - signed'({1'b0, tr_q[CW-1:0]});
  assign hp_d = PW'(dc) * PW'(signed'({1'b0, col_step}));
  assign vp_d = PW'(dr) * PW'(signed'({1'b0, row_step}));
  assign idx_calc = XW'(tr_q[CW-1:0]) * XW'(col_count) + XW'(tc_q[CW-1:0]);
  assign in_rng = (XW'(cr_q) < XW'(row_count)) && (XW'(tr_q) < XW'(row_count))
                  && (XW'(tc_q) < XW'(col_count));

  // shorter way round
  assign hx = HW'(hp_q);
  always_comb begin
    if (hx > HALF_S) h = hx - FULL_S;
    else if (hx < -HALF_S) h = hx + FULL_S;
    else h = hx;
  end
  assign v = HW'(vp_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_index <= '0;
      col_count <= CW'(1);
      row_count <= CW'(1);
      col_step  <= '0;
      row_step  <= '0;
      pan_off   <= '0;
      tilt_off  <= '0;
    end else begin
      if (cmd.take_step) begin
        if (cmd.axis) begin
          row_count <= n_q;
          row_step  <= SW'(quo);
        end else begin
          col_count <= n_q;
          col_step  <= SW'(quo);
        end
      end
      if (cmd.big_fit) begin
        if (cmd.axis) begin
          row_count <= CW'(1);
          row_step  <= lens;
        end else begin
          col_count <= CW'(1);
          col_step  <= lens;
        end
      end
      if (cmd.start_clr) begin
        cur_index <= '0;
        pan_off   <= '0;
        tilt_off  <= '0;
      end
      if (cmd.apply && in_rng_q) begin
        cur_index <= idx_q;
        pan_off   <= pan_off + h[MW-1:0];
        tilt_off  <= tilt_off + v[MW-1:0];
      end
      if (cmd.home) begin
        pan_off  <= '0;
        tilt_off <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trim_go) trim_q <= 16'(trim_x >> 8);
    if (cmd.take_tdeg) tdeg_q <= 9'(trim_prod >> pgps_pkg::TRIM_SHIFT);
    if (cmd.full_tdeg) tdeg_q <= tot_deg;
    if (cmd.take_cnt) n_q <= n_clamp;
    if (cmd.take_cur) begin
      cr_q <= IW'(quo);
      cc_q <= CW'(rem);
    end
    if (cmd.take_tgt) begin
      tr_q <= IW'(quo);
      tc_q <= IW'(rem);
    end
    if (cmd.tgt_in) begin
      tr_q <= IW'(trow_q);
      tc_q <= IW'(tcol_q);
    end
    if (cmd.tgt_zero) begin
      tr_q <= '0;
      tc_q <= '0;
    end
    if (cmd.mul) begin
      hp_q     <= hp_d;
      vp_q     <= vp_d;
      idx_q    <= IW'(idx_calc);
      in_rng_q <= in_rng;
    end
    if (cmd.start_clr) begin
      res_ok   <= 1'b1;
      res_pan  <= '0;
      res_tilt <= '0;
    end
    if (cmd.apply) begin
      res_ok   <= in_rng_q;
      res_pan  <= in_rng_q ? h[MW-1:0] : '0;
      res_tilt <= in_rng_q ? v[MW-1:0] : '0;
    end
    if (cmd.home) begin
      res_ok   <= 1'b1;
      res_pan  <= -pan_off;
      res_tilt <= -tilt_off;
    end
    if (cmd.reject) begin
      res_ok   <= 1'b0;
      res_pan  <= '0;
      res_tilt <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {1'b0,
                  pgps_pkg::CNT_OUT_W'(row_count),
                  pgps_pkg::CNT_OUT_W'(col_count),
                  cur_index, res_tilt, res_pan, res_ok};
    end
  end

  assign stat.mode        = mode_q;
  assign stat.div_done    = div_done;
  assign stat.div_busy    = div_busy;
  assign stat.lens_big    = DW'(lens) > DW'({tot_deg, 8'b0});
  assign stat.full_circle = (tot_deg == 9'(pgps_pkg::FULL_DEG));
  assign stat.cur_zero    = (cur_index == '0);
  assign stat.out_free    = !m_tvalid || m_tready;

endmodule

### hdl/pgps_ctrl.sv
// controller state machine sequencing grid fit and head moves
// depends on pgps_pkg
module pgps_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  pgps_pkg::stat_t stat,
  output pgps_pkg::cmd_t  cmd
);

  pgps_pkg::state_t state, state_next;
  logic             axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgps_pkg::ST_IDLE;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next  = state;
    axis_next   = axis;
    cmd         = '0;
    cmd.axis    = axis;
    cmd.div_sel = pgps_pkg::DS_CUR;
    s_tready    = 1'b0;
    case (state)
      pgps_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = pgps_pkg::ST_DISPATCH;
        end
      end
      pgps_pkg::ST_DISPATCH: begin
        case (stat.mode)
          pgps_pkg::MODE_START: begin
            axis_next  = 1'b0;
            state_next = pgps_pkg::ST_AXIS;
          end
          pgps_pkg::MODE_NEXT, pgps_pkg::MODE_GOTO_RC, pgps_pkg::MODE_GOTO_IDX,
          pgps_pkg::MODE_END: begin
            cmd.div_go = 1'b1;
            state_next = pgps_pkg::ST_CUR_DIV;
          end
          pgps_pkg::MODE_PREV: begin
            if (stat.cur_zero) begin
              cmd.reject = 1'b1;
              state_next = pgps_pkg::ST_DONE;
            end else begin
              cmd.div_go = 1'b1;
              state_next = pgps_pkg::ST_CUR_DIV;
            end
          end
          pgps_pkg::MODE_HOME: begin
            cmd.home   = 1'b1;
            state_next = pgps_pkg::ST_DONE;
          end
          default: begin
            cmd.reject = 1'b1;
            state_next = pgps_pkg::ST_DONE;
          end
        endcase
      end
      pgps_pkg::ST_AXIS: begin
        if (stat.lens_big) begin
          cmd.big_fit = 1'b1;
          state_next  = pgps_pkg::ST_AXIS_END;
        end else if (stat.full_circle) begin
          cmd.full_tdeg = 1'b1;
          state_next    = pgps_pkg::ST_CNT_GO;
        end else begin
          cmd.trim_go = 1'b1;
          state_next  = pgps_pkg::ST_TRIM;
        end
      end
      pgps_pkg::ST_TRIM: begin
        cmd.take_tdeg = 1'b1;
        state_next    = pgps_pkg::ST_CNT_GO;
      end
      pgps_pkg::ST_CNT_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = pgps_pkg::DS_CNT;
        state_next  = pgps_pkg::ST_CNT_DIV;
      end
      pgps_pkg::ST_CNT_DIV: begin
        if (stat.div_done) begin
          cmd.take_cnt = 1'b1;
          state_next   = pgps_pkg::ST_STEP_GO;
        end
      end
      pgps_pkg::ST_STEP_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = pgps_pkg::DS_STEP;
        state_next  = pgps_pkg::ST_STEP_DIV;
      end
      pgps_pkg::ST_STEP_DIV: begin
        if (stat.div_done) begin
          cmd.take_step = 1'b1;
          state_next    = pgps_pkg::ST_AXIS_END;
        end
      end
      pgps_pkg::ST_AXIS_END: begin
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = pgps_pkg::ST_AXIS;
        end else begin
          cmd.start_clr = 1'b1;
          state_next    = pgps_pkg::ST_DONE;
        end
      end
      pgps_pkg::ST_CUR_DIV: begin
        if (stat.div_done) begin
          cmd.take_cur = 1'b1;
          case (stat.mode)
            pgps_pkg::MODE_GOTO_RC: begin
              cmd.tgt_in = 1'b1;
              state_next = pgps_pkg::ST_MUL;
            end
            pgps_pkg::MODE_END: begin
              cmd.tgt_zero = 1'b1;
              state_next   = pgps_pkg::ST_MUL;
            end
            default: state_next = pgps_pkg::ST_TGT_GO;
          endcase
        end
      end
      pgps_pkg::ST_TGT_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = pgps_pkg::DS_TGT;
        state_next  = pgps_pkg::ST_TGT_DIV;
      end
      pgps_pkg::ST_TGT_DIV: begin
        cmd.div_sel = pgps_pkg::DS_TGT;
        if (stat.div_done) begin
          cmd.take_tgt = 1'b1;
          state_next   = pgps_pkg::ST_MUL;
        end
      end
      pgps_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = pgps_pkg::ST_APPLY;
      end
      pgps_pkg::ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = pgps_pkg::ST_DONE;
      end
      pgps_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = pgps_pkg::ST_IDLE;
        end
      end
      default: state_next = pgps_pkg::ST_IDLE;
    endcase
  end

endmodule

### hdl/pano_grid_position_sequencer_unit.sv
// panorama grid position sequencer, one command item in, one result item out.
// start: per axis a trim (none for a full circle), then count and step through the shared
// bit-serial divider (four passes at most); an axis the lens spans gets a count of one instead.
// next, prev, goto index: two divider passes plus multiply and apply; goto row/col
// and end: one pass, multiply and apply; home, prev at zero, unknown mode: no pass. output may stall.
// one item in work at a time; output is registered. sync reset: default config, 1 x 1 grid.
`include "assert_macros.svh"

module pano_grid_position_sequencer_unit #(
  parameter int OVERLAP_PERCENT = pgps_pkg::OVERLAP_DEF,
  parameter int MAX_GRID        = pgps_pkg::MAX_GRID_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pgps_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [pgps_pkg::CFG_DW-1:0]      cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // mode[2:0], target_row[11:3], target_col[20:12], target_index[38:21], zero pad
  input  logic [pgps_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // ok[0], pan_move[24:1], tilt_move[48:25], photo_index[66:49],
  // columns[76:67], rows[86:77], zero pad
  output logic [pgps_pkg::OUT_TDATA_W-1:0] m_tdata
);

  pgps_pkg::cmd_t  cmd;
  pgps_pkg::stat_t stat;

  pgps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pgps_datapath #(
    .OVERLAP_PERCENT (OVERLAP_PERCENT),
    .MAX_GRID        (MAX_GRID)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

  `ASSERT_IMPL(a_div_idle_on_go, clk, rst, cmd.div_go, !stat.div_busy)
  `ASSERT_NEXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_NEXT(a_result_shown, clk, rst, cmd.out_load, m_tvalid)

endmodule
